// ===== design/tpta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpta_pkg
// Shared types and constants of the two-plane track acceptance block.
// ----------------------------------------------------------------------------
package tpta_pkg;

	localparam bit FIRST_ORDER_YX = 1'b0;
	localparam bit SECOND_ORDER_YX = 1'b1;
	localparam int SLOPE_FRACTION_BITS = 16;

	// slope magnitude bits after clamping
	localparam int QW = 21 + SLOPE_FRACTION_BITS;
	// dividend bits: numerator magnitude shifted plus rounding term
	localparam int DW = QW + 3;
	localparam int NMW = 23;
	localparam int ZMW = 21;
	// divisor is twice the plane distance
	localparam int BW = 22;
	// multiplier split of the slope
	localparam int HALF = (QW + 1) / 2;
	localparam int HIW = QW - HALF;
	localparam int LOW_PW = HALF + 20;
	localparam int HIGH_PW = HIW + 20;
	localparam int PW = QW + 20;
	localparam int RW = PW - SLOPE_FRACTION_BITS + 1;
	localparam int SW = RW + 2;
	localparam logic [18:0] LEN_MAX = 19'h7FFFF;
	localparam logic [QW-1:0] SLOPE_LIM = {QW{1'b1}};

	typedef enum logic [3:0] {
		REG_FIRST_LOW_EDGE = 4'd0,
		REG_FIRST_WIDTH = 4'd1,
		REG_FIRST_Z_BOTTOM = 4'd2,
		REG_FIRST_Z_TOP = 4'd3,
		REG_SECOND_LOW_EDGE = 4'd4,
		REG_SECOND_WIDTH = 4'd5,
		REG_SECOND_Z_BOTTOM = 4'd6,
		REG_SECOND_Z_TOP = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [19:0] first_low_edge;
		logic [18:0] first_width;
		logic signed [19:0] first_z_bottom;
		logic signed [19:0] first_z_top;
		logic signed [19:0] second_low_edge;
		logic [18:0] second_width;
		logic signed [19:0] second_z_bottom;
		logic signed [19:0] second_z_top;
	} cfg_t;

	typedef struct packed {
		logic axis_sel;
		logic signed [19:0] hit_offset;
	} request_t;

	typedef struct packed {
		logic [18:0] overlap_length;
		logic plane_error;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [NMW-1:0] num_mag;
		logic [ZMW-1:0] zd_mag;
		logic neg;
		logic err;
	} work_t;

endpackage

// ===== design/two_plane_track_acceptance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_plane_track_acceptance
// Overlap length of four face apertures shifted along a two-plane track.
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle unless a full, unpopped result queue
//   stalls the back end; the slope divider is a pipeline of
//   21 + SLOPE_FRACTION_BITS stages, one quotient bit each
// reset: arst_n clears queues and valid bits, config registers read as zero
// ----------------------------------------------------------------------------
module two_plane_track_acceptance (
	input  logic clk,
	input  logic arst_n,
	// input queue side
	input  tpta_pkg::request_t request,
	input  logic push,
	output logic full,
	// result queue side
	output tpta_pkg::result_t result,
	output logic empty,
	input  logic pop,
	// register writes
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [19:0] cfg_data
);
	tpta_pkg::cfg_t cfg_q;
	tpta_pkg::work_t fr_work_s1, mq_dout;
	logic fr_valid_s1;
	logic mq_wr, mq_rd, mq_full, mq_empty;

	// register bank, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpta_pkg::REG_FIRST_LOW_EDGE: cfg_q.first_low_edge <= cfg_data;
				tpta_pkg::REG_FIRST_WIDTH: cfg_q.first_width <= cfg_data[18:0];
				tpta_pkg::REG_FIRST_Z_BOTTOM: cfg_q.first_z_bottom <= cfg_data;
				tpta_pkg::REG_FIRST_Z_TOP: cfg_q.first_z_top <= cfg_data;
				tpta_pkg::REG_SECOND_LOW_EDGE: cfg_q.second_low_edge <= cfg_data;
				tpta_pkg::REG_SECOND_WIDTH: cfg_q.second_width <= cfg_data[18:0];
				tpta_pkg::REG_SECOND_Z_BOTTOM: cfg_q.second_z_bottom <= cfg_data;
				tpta_pkg::REG_SECOND_Z_TOP: cfg_q.second_z_top <= cfg_data;
				// unknown index: transfer dropped
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// front: plane choice, numerator, plane distance
	tpta_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.request(request),
		.push(push),
		.full(full),
		.q_full(mq_full),
		.work_s1(fr_work_s1),
		.valid_s1(fr_valid_s1)
	);

	// decoupling queue
	assign mq_wr = fr_valid_s1 && !mq_full;

	tpta_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(mq_wr),
		.din(fr_work_s1),
		.rd(mq_rd),
		.dout(mq_dout),
		.full(mq_full),
		.empty(mq_empty)
	);

	// back: divide, shift faces, intersect, hold results
	tpta_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(mq_empty),
		.q_data(mq_dout),
		.q_rd(mq_rd),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	// coinciding planes never report a length
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.plane_error) |-> (result.overlap_length == 19'd0))
		else $error("plane error with nonzero length");

	// the middle queue is never read while empty
	a_mq_rd: assert property (@(posedge clk) disable iff (!arst_n)
		mq_rd |-> !mq_empty)
		else $error("middle queue read while empty");

	// a result leaves only through a pop transfer
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result lost without pop");

endmodule

// ===== design/tpta_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpta_front
// Picks the measuring planes and forms slope numerator and plane distance.
// ----------------------------------------------------------------------------
module tpta_front (
	input  logic clk,
	input  logic arst_n,
	input  tpta_pkg::cfg_t cfg,
	input  tpta_pkg::request_t request,
	input  logic push,
	output logic full,
	input  logic q_full,
	output tpta_pkg::work_t work_s1,
	output logic valid_s1
);
	logic ready;
	logic signed [19:0] z0, z1;
	logic signed [20:0] zdiff;
	logic signed [23:0] num2;
	tpta_pkg::work_t w;

	assign ready = !valid_s1 || !q_full;
	assign full = !ready;

	always_comb begin
		z0 = ((tpta_pkg::FIRST_ORDER_YX != 1'b0) != request.axis_sel) ?
			cfg.first_z_top : cfg.first_z_bottom;
		z1 = ((tpta_pkg::SECOND_ORDER_YX != 1'b0) != request.axis_sel) ?
			cfg.second_z_top : cfg.second_z_bottom;
		zdiff = 21'(z0) - 21'(z1);
		num2 = {{3{request.hit_offset[19]}}, request.hit_offset, 1'b0}
			+ {{3{cfg.first_low_edge[19]}}, cfg.first_low_edge, 1'b0}
			+ {5'b0, cfg.first_width}
			- {{3{cfg.second_low_edge[19]}}, cfg.second_low_edge, 1'b0}
			- {5'b0, cfg.second_width};
		w.num_mag = num2[23] ? 23'(-num2) : num2[22:0];
		w.zd_mag = zdiff[20] ? 21'(-zdiff) : 21'(zdiff);
		w.neg = num2[23] ^ zdiff[20];
		w.err = (zdiff == 21'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			work_s1 <= w;
		end
	end

endmodule

// ===== design/tpta_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpta_queue
// Four-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tpta_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  tpta_pkg::work_t din,
	input  logic rd,
	output tpta_pkg::work_t dout,
	output logic full,
	output logic empty
);
	tpta_pkg::work_t mem_q [0:3];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 2'd0;
			rp_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

// ===== design/tpta_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpta_back
// Pipelined slope divider, face shifts, aperture intersection, result queue.
// ----------------------------------------------------------------------------
module tpta_back (
	input  logic clk,
	input  logic arst_n,
	input  tpta_pkg::cfg_t cfg,
	input  logic q_empty,
	input  tpta_pkg::work_t q_data,
	output logic q_rd,
	output tpta_pkg::result_t result,
	output logic empty,
	input  logic pop
);
	localparam int QW = tpta_pkg::QW;
	localparam int BW = tpta_pkg::BW;
	localparam int SW = tpta_pkg::SW;
	localparam int F = tpta_pkg::SLOPE_FRACTION_BITS;

	logic en;
	logic pop_ok;

	// divider stages, index 0 is the entry stage
	logic [QW:0] dv_v;
	logic [BW-1:0] dv_rem [0:QW];
	logic [BW-1:0] dv_b [0:QW];
	logic [QW-1:0] dv_div [0:QW];
	logic [QW-1:0] dv_quo [0:QW];
	logic [QW:0] dv_neg, dv_err, dv_ovf;

	logic [tpta_pkg::DW-1:0] dividend;
	logic [2:0] dv_hi;
	logic [BW-1:0] b_in;

	// face arithmetic stages
	logic v_m1, v_m2, v_m3, v_m4, v_m5, v_m6;
	logic err_m1, err_m2, err_m3, err_m4, err_m5;
	logic signed [19:0] fz [0:3];
	logic [19:0] fzm [0:3];
	logic [QW-1:0] qv;
	logic [tpta_pkg::LOW_PW-1:0] pp_lo_m1 [0:3];
	logic [tpta_pkg::HIGH_PW-1:0] pp_hi_m1 [0:3];
	logic [3:0] neg_m1, neg_m2;
	logic [tpta_pkg::PW-1:0] p_m2 [0:3];
	logic signed [SW-1:0] s_m3 [0:3];
	logic signed [SW-1:0] qmin_m4 [0:3];
	logic signed [SW-1:0] qmax_m4 [0:3];
	logic signed [SW-1:0] rmin_m5 [0:1];
	logic signed [SW-1:0] rmax_m5 [0:1];
	logic signed [SW-1:0] rmin, rmax, diff;
	tpta_pkg::result_t res_m6, res_c;

	// result queue
	tpta_pkg::result_t oq_q [0:3];
	logic [1:0] owp_q, orp_q;
	logic [2:0] ocnt_q;
	logic oq_wr;

	assign pop_ok = pop && (ocnt_q != 3'd0);
	assign en = !(v_m6 && (ocnt_q == 3'd4) && !pop_ok);
	assign q_rd = en && !q_empty;

	// entry stage: dividend = |num| * 2^F + |zd|, divisor = 2 |zd|
	always_comb begin
		dividend = tpta_pkg::DW'({q_data.num_mag, {F{1'b0}}})
			+ tpta_pkg::DW'(q_data.zd_mag);
		dv_hi = dividend[tpta_pkg::DW-1:QW];
		b_in = {q_data.zd_mag, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v <= '0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			v_m5 <= 1'b0;
			v_m6 <= 1'b0;
		end else if (en) begin
			dv_v <= {dv_v[QW-1:0], q_rd};
			v_m1 <= dv_v[QW];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			v_m5 <= v_m4;
			v_m6 <= v_m5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem[0] <= BW'(dv_hi);
			dv_b[0] <= b_in;
			dv_div[0] <= dividend[QW-1:0];
			dv_quo[0] <= '0;
			dv_neg[0] <= q_data.neg;
			dv_err[0] <= q_data.err;
			dv_ovf[0] <= (BW'(dv_hi) >= b_in);
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [BW:0] trial;
		logic ge;
		assign trial = {dv_rem[k-1], dv_div[k-1][QW-1]};
		assign ge = (trial >= {1'b0, dv_b[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[k] <= ge ? BW'(trial - {1'b0, dv_b[k-1]}) : trial[BW-1:0];
				dv_b[k] <= dv_b[k-1];
				dv_div[k] <= {dv_div[k-1][QW-2:0], 1'b0};
				dv_quo[k] <= {dv_quo[k-1][QW-2:0], ge};
				dv_neg[k] <= dv_neg[k-1];
				dv_err[k] <= dv_err[k-1];
				dv_ovf[k] <= dv_ovf[k-1];
			end
		end
	end

	always_comb begin
		fz[0] = cfg.first_z_bottom;
		fz[1] = cfg.first_z_top;
		fz[2] = cfg.second_z_bottom;
		fz[3] = cfg.second_z_top;
		for (int f = 0; f < 4; f++) begin
			fzm[f] = fz[f][19] ? 20'(-fz[f]) : fz[f];
		end
		qv = dv_ovf[QW] ? tpta_pkg::SLOPE_LIM : dv_quo[QW];
	end

	// m1: partial products of slope times face height
	always_ff @(posedge clk) begin
		if (en) begin
			err_m1 <= dv_err[QW];
			for (int f = 0; f < 4; f++) begin
				pp_lo_m1[f] <= tpta_pkg::LOW_PW'(qv[tpta_pkg::HALF-1:0])
					* tpta_pkg::LOW_PW'(fzm[f]);
				pp_hi_m1[f] <= tpta_pkg::HIGH_PW'(qv[QW-1:tpta_pkg::HALF])
					* tpta_pkg::HIGH_PW'(fzm[f]);
				neg_m1[f] <= dv_neg[QW] ^ fz[f][19];
			end
		end
	end

	// m2: full product
	always_ff @(posedge clk) begin
		if (en) begin
			err_m2 <= err_m1;
			neg_m2 <= neg_m1;
			for (int f = 0; f < 4; f++) begin
				p_m2[f] <= (tpta_pkg::PW'(pp_hi_m1[f]) << tpta_pkg::HALF)
					+ tpta_pkg::PW'(pp_lo_m1[f]);
			end
		end
	end

	// m3: round to integer, ties away from zero, apply sign
	always_ff @(posedge clk) begin
		logic [tpta_pkg::RW-1:0] r;
		if (en) begin
			err_m3 <= err_m2;
			for (int f = 0; f < 4; f++) begin
				r = tpta_pkg::RW'(p_m2[f][tpta_pkg::PW-1:F]) + tpta_pkg::RW'(p_m2[f][F-1]);
				s_m3[f] <= neg_m2[f] ? -SW'(r) : SW'(r);
			end
		end
	end

	// m4: shifted aperture edges per face
	always_ff @(posedge clk) begin
		if (en) begin
			err_m4 <= err_m3;
			qmin_m4[0] <= SW'(cfg.first_low_edge) - s_m3[0];
			qmin_m4[1] <= SW'(cfg.first_low_edge) - s_m3[1];
			qmin_m4[2] <= SW'(cfg.second_low_edge) - s_m3[2];
			qmin_m4[3] <= SW'(cfg.second_low_edge) - s_m3[3];
			qmax_m4[0] <= SW'(cfg.first_low_edge) + SW'(cfg.first_width) - s_m3[0];
			qmax_m4[1] <= SW'(cfg.first_low_edge) + SW'(cfg.first_width) - s_m3[1];
			qmax_m4[2] <= SW'(cfg.second_low_edge) + SW'(cfg.second_width) - s_m3[2];
			qmax_m4[3] <= SW'(cfg.second_low_edge) + SW'(cfg.second_width) - s_m3[3];
		end
	end

	// m5: pairwise intersection
	always_ff @(posedge clk) begin
		if (en) begin
			err_m5 <= err_m4;
			for (int h = 0; h < 2; h++) begin
				rmin_m5[h] <= (qmin_m4[2*h] > qmin_m4[2*h+1]) ? qmin_m4[2*h] : qmin_m4[2*h+1];
				rmax_m5[h] <= (qmax_m4[2*h] < qmax_m4[2*h+1]) ? qmax_m4[2*h] : qmax_m4[2*h+1];
			end
		end
	end

	// m6: final intersection and saturated length
	always_comb begin
		rmin = (rmin_m5[0] > rmin_m5[1]) ? rmin_m5[0] : rmin_m5[1];
		rmax = (rmax_m5[0] < rmax_m5[1]) ? rmax_m5[0] : rmax_m5[1];
		diff = rmax - rmin;
		res_c.plane_error = err_m5;
		if (err_m5 || (rmin > rmax)) begin
			res_c.overlap_length = '0;
		end else if (|diff[SW-1:19]) begin
			res_c.overlap_length = tpta_pkg::LEN_MAX;
		end else begin
			res_c.overlap_length = diff[18:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_m6 <= res_c;
		end
	end

	// result queue, last stage only moves when there is room
	assign oq_wr = en && v_m6;
	assign empty = (ocnt_q == 3'd0);
	assign result = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 2'd0;
			orp_q <= 2'd0;
			ocnt_q <= 3'd0;
		end else begin
			if (oq_wr) owp_q <= owp_q + 2'd1;
			if (pop_ok) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(oq_wr) - 3'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[owp_q] <= res_m6;
		end
	end

endmodule

// ===== tb/tpta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpta_checker
// Watches request, result and register channels of the track acceptance
// block, predicts every overlap length and compares in transfer order.
// ----------------------------------------------------------------------------
module tpta_checker (
	input  logic clk,
	input  logic arst_n,
	input  tpta_pkg::request_t request,
	input  logic push,
	input  logic full,
	input  tpta_pkg::result_t result,
	input  logic empty,
	input  logic pop,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [19:0] cfg_data,
	output int errors,
	output int waiting
);
	import tpta_pkg::*;

	cfg_t geom;
	result_t overlap_q[$];

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// slope * z / 2^F rounded half away from zero
	function automatic longint face_offset(longint slope, longint z);
		longint p;
		longint r;
		begin
			p = mag(slope) * mag(z);
			r = (p >>> SLOPE_FRACTION_BITS) + ((p >>> (SLOPE_FRACTION_BITS - 1)) & 1);
			return ((slope < 0) != (z < 0)) ? -r : r;
		end
	endfunction

	function automatic result_t predict_overlap(cfg_t g, request_t r);
		longint lo[2], wd[2], zb[2], zt[2], zm[2];
		longint zdiff, num2, a, b, q, slope, s, z, rmin, rmax, len;
		bit yx;
		result_t res;
		begin
			lo[0] = g.first_low_edge;   wd[0] = g.first_width;
			zb[0] = g.first_z_bottom;   zt[0] = g.first_z_top;
			lo[1] = g.second_low_edge;  wd[1] = g.second_width;
			zb[1] = g.second_z_bottom;  zt[1] = g.second_z_top;
			for (int u = 0; u < 2; u++) begin
				yx = (u == 0) ? FIRST_ORDER_YX : SECOND_ORDER_YX;
				zm[u] = (yx != r.axis_sel) ? zt[u] : zb[u];
			end
			res = '0;
			zdiff = zm[0] - zm[1];
			if (zdiff == 0) begin
				res.plane_error = 1'b1;
				return res;
			end
			// numerator in half units so the centers stay exact
			num2 = 2 * longint'(r.hit_offset) + 2 * lo[0] + wd[0] - 2 * lo[1] - wd[1];
			a = mag(num2) <<< SLOPE_FRACTION_BITS;
			b = 2 * mag(zdiff);
			q = (a + b / 2) / b;
			if (q > (longint'(1) <<< QW) - 1)
				q = (longint'(1) <<< QW) - 1;
			slope = ((num2 < 0) != (zdiff < 0)) ? -q : q;
			rmin = 0;
			rmax = 0;
			for (int f = 0; f < 4; f++) begin
				z = (f & 1) ? zt[f >> 1] : zb[f >> 1];
				s = face_offset(slope, z);
				if (f == 0 || lo[f >> 1] - s > rmin)
					rmin = lo[f >> 1] - s;
				if (f == 0 || lo[f >> 1] + wd[f >> 1] - s < rmax)
					rmax = lo[f >> 1] + wd[f >> 1] - s;
			end
			len = 0;
			if (rmin <= rmax) begin
				len = rmax - rmin;
				if (len > 524287)
					len = 524287;
			end
			res.overlap_length = len[18:0];
			return res;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_res;
		if (!arst_n) begin
			geom <= '0;
			overlap_q.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST_LOW_EDGE:  geom.first_low_edge <= cfg_data;
					REG_FIRST_WIDTH:     geom.first_width <= cfg_data[18:0];
					REG_FIRST_Z_BOTTOM:  geom.first_z_bottom <= cfg_data;
					REG_FIRST_Z_TOP:     geom.first_z_top <= cfg_data;
					REG_SECOND_LOW_EDGE: geom.second_low_edge <= cfg_data;
					REG_SECOND_WIDTH:    geom.second_width <= cfg_data[18:0];
					REG_SECOND_Z_BOTTOM: geom.second_z_bottom <= cfg_data;
					REG_SECOND_Z_TOP:    geom.second_z_top <= cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				overlap_q.push_back(predict_overlap(geom, request));
			if (pop && !empty) begin
				if (overlap_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result len=%0d err=%0b",
							result.overlap_length, result.plane_error);
					errors <= errors + 1;
				end else begin
					exp_res = overlap_q.pop_front();
					if (result.overlap_length !== exp_res.overlap_length ||
						result.plane_error !== exp_res.plane_error) begin
						if (errors < 10)
							$display("mismatch: len exp %0d got %0d, err exp %0b got %0b",
								exp_res.overlap_length, result.overlap_length,
								exp_res.plane_error, result.plane_error);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign waiting = overlap_q.size();

endmodule

// ===== tb/tb_two_plane_track_acceptance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_plane_track_acceptance
// Loads a series of unit geometries, sends hit offsets under varying idle and
// stall patterns and lets the checker compare every overlap length.
// ----------------------------------------------------------------------------
module tb_two_plane_track_acceptance;
	import tpta_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	request_t request = '0;
	logic push = 1'b0;
	logic full;
	result_t result;
	logic empty;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	int errors;
	int waiting;
	int sent = 0;
	int got = 0;
	// percent chances of an idle sender cycle and of a stalled receiver cycle
	int gap_pct = 0;
	int stall_pct = 0;
	// span of the small offsets for the current geometry
	int offset_span = 1000;

	always #4 clk = ~clk;

	two_plane_track_acceptance i_dut (
		.clk(clk), .arst_n(arst_n),
		.request(request), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tpta_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.request(request), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	// receiver side: stall at random, count result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				got <= got + 1;
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one register write, valid left high for a following write; block idle
	task automatic write_reg(logic [3:0] idx, logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_geometry(logic [19:0] lo0, logic [19:0] w0, logic [19:0] zb0,
		logic [19:0] zt0, logic [19:0] lo1, logic [19:0] w1, logic [19:0] zb1,
		logic [19:0] zt1);
		write_reg(REG_FIRST_LOW_EDGE, lo0);
		write_reg(REG_FIRST_WIDTH, w0);
		write_reg(REG_FIRST_Z_BOTTOM, zb0);
		write_reg(REG_FIRST_Z_TOP, zt0);
		write_reg(REG_SECOND_LOW_EDGE, lo1);
		write_reg(REG_SECOND_WIDTH, w1);
		write_reg(REG_SECOND_Z_BOTTOM, zb1);
		write_reg(REG_SECOND_Z_TOP, zt1);
		cfg_valid <= 1'b0;
	endtask

	// two stacked units centered near zero, planes well apart
	task automatic load_random_geometry();
		int w0, w1, zb0, zb1, sep;
		w0 = $urandom_range(16, 40000);
		w1 = $urandom_range(16, 40000);
		zb0 = int'($urandom_range(200000)) - 100000;
		sep = $urandom_range(1000, 300000);
		zb1 = $urandom_range(1) ? zb0 + sep : zb0 - sep;
		load_geometry(20'(-(w0 / 2) + int'($urandom_range(200)) - 100), 20'(w0), 20'(zb0),
			20'(zb0 + int'($urandom_range(8000))),
			20'(-(w1 / 2) + int'($urandom_range(200)) - 100), 20'(w1), 20'(zb1),
			20'(zb1 + int'($urandom_range(8000))));
		offset_span = w0 + w1;
	endtask

	// input side: optional idle cycles, then hold push until the transfer
	task automatic send_hit(logic axis, logic [19:0] offset);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		request <= '{axis_sel: axis, hit_offset: offset};
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic send_random_hit();
		logic [19:0] off;
		if ($urandom_range(3) == 0)
			off = 20'($urandom);
		else
			off = 20'(int'($urandom_range(2 * offset_span)) - offset_span);
		send_hit(1'($urandom_range(1)), off);
	endtask

	// drain all results, then let the pipeline run empty
	task automatic settle();
		push <= 1'b0;
		while (sent != got) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 56; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 56; end
			default: begin gap_pct = 35; stall_pct = 35; end
		endcase
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: all planes coincide
		send_hit(1'b0, 20'sd5);
		send_hit(1'b1, -20'sd5);
		settle();

		// directed: plain geometry, offset extremes on both axes
		load_geometry(-20'sd800, 20'd1600, -20'sd40000, -20'sd39000,
			-20'sd800, 20'd1600, 20'sd40000, 20'sd41000);
		@(posedge clk);
		// index outside the register map must be ignored
		write_reg(4'd8 + 4'($urandom_range(7)), 20'($urandom));
		cfg_valid <= 1'b0;
		for (int ax = 0; ax < 2; ax++) begin
			send_hit(1'(ax), 20'sd0);
			send_hit(1'(ax), 20'sd1);
			send_hit(1'(ax), -20'sd1);
			send_hit(1'(ax), 20'sd400);
			send_hit(1'(ax), -20'sd1600);
			send_hit(1'(ax), 20'sd3000);
			send_hit(1'(ax), 20'sh7FFFF);
			send_hit(1'(ax), 20'sh80000);
		end
		settle();

		// coinciding measuring planes on the X axis only
		load_geometry(-20'sd100, 20'd200, 20'sd5000, 20'sd6000,
			-20'sd100, 20'd200, -20'sd9000, 20'sd5000);
		send_hit(1'b0, 20'sd7);
		send_hit(1'b1, 20'sd7);
		send_hit(1'b1, 20'sd0);
		settle();

		// register extremes: widest apertures, far edges and faces
		load_geometry(20'sh80000, 20'h7FFFF, 20'sh80000, 20'sh7FFFF,
			20'sh80000, 20'h7FFFF, 20'sh7FFFF, 20'sh80000);
		send_hit(1'b0, 20'sd0);
		send_hit(1'b1, 20'sd0);
		send_hit(1'b0, 20'sh7FFFF);
		send_hit(1'b1, 20'sh80000);
		settle();
		load_geometry(20'sh7FFFF, 20'h00000, 20'sh7FFFF, 20'sh7FFFF,
			20'sh80000, 20'h7FFFF, 20'sh80000, 20'sh80000);
		send_hit(1'b0, 20'sh80000);
		send_hit(1'b1, 20'sh7FFFF);
		settle();

		// random part: fresh geometry each phase, idling pattern rotates
		for (int ph = 0; ph < 16; ph++) begin
			load_random_geometry();
			set_idling(ph);
			for (int n = 0; n < 85; n++)
				send_random_hit();
			settle();
		end

		if (errors == 0 && waiting == 0)
			$display("[two_plane_track_acceptance] OK");
		else
			$display("[two_plane_track_acceptance] ERROR");
		$finish;
	end

	initial begin
		#(8 * 400000);
		$display("[two_plane_track_acceptance] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tpta_pkg.sv
design/tpta_front.sv
design/tpta_queue.sv
design/tpta_back.sv
design/two_plane_track_acceptance.sv
tb/tpta_checker.sv
tb/tb_two_plane_track_acceptance.sv
